FILE: rtl/mep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types, constants and fixed-point helpers for the escape-time unit.
// ----------------------------------------------------------------------------
package mep_pkg;

   localparam int DATA_W = 24;
   localparam int PROD_W = 2 * DATA_W;
   // wide enough for any iteration limit up to 63
   localparam int CNT_W  = 6;

   localparam int MAX_ITER_DEFAULT      = 18;
   localparam int FRAC_BITS_DEFAULT     = 12;
   localparam int SCREEN_WIDTH_DEFAULT  = 320;
   localparam int SCREEN_HEIGHT_DEFAULT = 240;

   // register map
   localparam logic [1:0] REG_ZOOM_SCALE  = 2'd0;
   localparam logic [1:0] REG_OFFSET_REAL = 2'd1;
   localparam logic [1:0] REG_OFFSET_IMAG = 2'd2;

   localparam logic signed [DATA_W-1:0] ZOOM_SCALE_RESET  = 24'sd8192;
   localparam logic signed [DATA_W-1:0] OFFSET_REAL_RESET = -24'sd4096;
   localparam logic signed [DATA_W-1:0] OFFSET_IMAG_RESET = 24'sd0;

   // palette bands
   localparam logic [CNT_W-1:0] PAL_LOW_LAST  = 6'd7;
   localparam logic [CNT_W-1:0] PAL_MID_LAST  = 6'd14;
   localparam logic [7:0]       PAL_MID_BASE  = 8'd7;
   localparam logic [7:0]       PAL_HIGH_BASE = 8'd231;

   typedef struct packed {
      logic                     valid;
      logic                     done;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] cr;
      logic signed [DATA_W-1:0] ci;
      logic signed [DATA_W-1:0] zr;
      logic signed [DATA_W-1:0] zi;
   } mep_iter_type;

   // product scaled down by 2^frac, rounded toward zero, wrapped to 24 bits
   function automatic logic signed [DATA_W-1:0] fx_trunc(
      input logic signed [PROD_W-1:0] p,
      input int unsigned              frac
   );
      logic signed [PROD_W-1:0] bias;
      logic signed [PROD_W-1:0] q;
      bias = p[PROD_W-1] ? ((PROD_W'(1) <<< frac) - PROD_W'(1)) : '0;
      q    = (p + bias) >>> frac;
      return q[DATA_W-1:0];
   endfunction

   // magnitude as unsigned, most negative value gives 2^23
   function automatic logic [DATA_W-1:0] fx_abs(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   function automatic logic [7:0] palette_of(input logic [CNT_W-1:0] i);
      logic [7:0] i8;
      logic [7:0] col;
      i8 = 8'(i);
      priority if (i == '0) begin
         col = 8'd0;
      end else if (i <= PAL_LOW_LAST) begin
         col = i8;
      end else if (i <= PAL_MID_LAST) begin
         col = PAL_MID_BASE + (i8 << 5);
      end else begin
         col = PAL_HIGH_BASE + (i8 << 3);
      end
      return col;
   endfunction

endpackage

FILE: rtl/mep_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_map
// Three-stage pixel to complex point mapping, both axes side by side.
// ----------------------------------------------------------------------------
module mep_map import mep_pkg::*; #(
   parameter int FRAC_BITS     = FRAC_BITS_DEFAULT,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [8:0]               pixel_x,
   input  logic [7:0]               pixel_y,
   input  logic signed [DATA_W-1:0] zoom_scale,
   input  logic signed [DATA_W-1:0] offset_real,
   input  logic signed [DATA_W-1:0] offset_imag,
   output mep_iter_type             iter_out
);

   localparam int PIX_W       = 10;
   localparam int HEIGHT_LOG  = $clog2(SCREEN_HEIGHT);
   localparam int RECIP_SHIFT = DATA_W + HEIGHT_LOG;
   localparam int RECIP_W     = DATA_W + 1;
   localparam int QPROD_W     = DATA_W + RECIP_W;
   // ceil(2^k / height): exact quotient for any 24-bit magnitude
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(SCREEN_HEIGHT) - 64'd1) / 64'(SCREEN_HEIGHT);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam logic signed [DATA_W-1:0] HALF = DATA_W'(1 << (FRAC_BITS - 1));

   logic [PIX_W-1:0] pix [2];
   logic signed [DATA_W-1:0] offs [2];

   logic                     v1_ff, v1_in;
   logic                     v2_ff, v2_in;
   logic                     v3_ff, v3_in;
   logic [QPROD_W-1:0]       qprod_ff [2];
   logic [QPROD_W-1:0]       qprod_in [2];
   logic                     neg_ff [2];
   logic                     neg_in [2];
   logic signed [PROD_W-1:0] zprod_ff [2];
   logic signed [PROD_W-1:0] zprod_in [2];
   logic signed [DATA_W-1:0] c_ff [2];
   logic signed [DATA_W-1:0] c_in [2];

   assign pix[0]  = PIX_W'(pixel_x);
   assign pix[1]  = PIX_W'(pixel_y);
   assign offs[0] = offset_real;
   assign offs[1] = offset_imag;

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [PIX_W+FRAC_BITS-1:0] pix_wide;
      logic [DATA_W-1:0]          s;
      logic [DATA_W-1:0]          s_mag;
      logic [DATA_W-1:0]          q_mag;
      logic signed [DATA_W-1:0]   q;
      logic signed [DATA_W-1:0]   t;

      always_comb begin
         // stage 1: magnitude of the scaled pixel times the reciprocal
         pix_wide    = (PIX_W + FRAC_BITS)'(pix[a]) << FRAC_BITS;
         s           = DATA_W'(pix_wide);
         neg_in[a]   = s[DATA_W-1];
         s_mag       = s[DATA_W-1] ? -s : s;
         qprod_in[a] = QPROD_W'(s_mag) * QPROD_W'(RECIP);
         // stage 2: signed quotient, centre, scale by zoom
         q_mag       = DATA_W'(qprod_ff[a] >> RECIP_SHIFT);
         q           = neg_ff[a] ? -$signed(q_mag) : $signed(q_mag);
         t           = q - HALF;
         zprod_in[a] = t * zoom_scale;
         // stage 3: rescale and shift by offset
         c_in[a]     = fx_trunc(zprod_ff[a], FRAC_BITS) + offs[a];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            qprod_ff[a] <= qprod_in[a];
            neg_ff[a]   <= neg_in[a];
            zprod_ff[a] <= zprod_in[a];
            c_ff[a]     <= c_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_comb begin
      iter_out.valid = v3_ff;
      iter_out.done  = 1'b0;
      iter_out.count = '0;
      iter_out.cr    = c_ff[0];
      iter_out.ci    = c_ff[1];
      iter_out.zr    = '0;
      iter_out.zi    = '0;
   end

endmodule

FILE: rtl/mep_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_cell
// One iteration of z = z^2 + c with the escape test, two register stages.
// ----------------------------------------------------------------------------
module mep_cell import mep_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int CELL_IDX  = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  mep_iter_type up_iter,
   output mep_iter_type dn_iter
);

   localparam logic [DATA_W-1:0] ESC_LIMIT = DATA_W'(2 << FRAC_BITS);
   localparam logic [CNT_W-1:0]  MY_COUNT  = CNT_W'(CELL_IDX);

   logic                     esc;
   logic signed [DATA_W-1:0] zsum;
   logic signed [DATA_W-1:0] zdiff;

   logic                     a_valid_ff, a_valid_in;
   logic                     a_done_ff, a_done_in;
   logic [CNT_W-1:0]         a_count_ff, a_count_in;
   logic signed [DATA_W-1:0] a_cr_ff, a_ci_ff;
   logic signed [PROD_W-1:0] a_sq_ff, a_sq_in;
   logic signed [PROD_W-1:0] a_xy_ff, a_xy_in;

   logic signed [DATA_W-1:0] nr;
   logic signed [DATA_W-1:0] xy;
   logic signed [DATA_W-1:0] ni;
   mep_iter_type             b_ff, b_in;

   always_comb begin
      esc        = (fx_abs(up_iter.zr) >= ESC_LIMIT) || (fx_abs(up_iter.zi) >= ESC_LIMIT);
      zsum       = up_iter.zr + up_iter.zi;
      zdiff      = up_iter.zr - up_iter.zi;
      a_valid_in = up_iter.valid;
      a_done_in  = up_iter.done | esc;
      // first escape fixes the count, later cells keep it
      a_count_in = (!up_iter.done && esc) ? MY_COUNT : up_iter.count;
      a_sq_in    = zsum * zdiff;
      a_xy_in    = up_iter.zr * up_iter.zi;
   end

   always_comb begin
      nr         = fx_trunc(a_sq_ff, FRAC_BITS);
      xy         = fx_trunc(a_xy_ff, FRAC_BITS);
      ni         = {xy[DATA_W-2:0], 1'b0};
      b_in.valid = a_valid_ff;
      b_in.done  = a_done_ff;
      b_in.count = a_count_ff;
      b_in.cr    = a_cr_ff;
      b_in.ci    = a_ci_ff;
      b_in.zr    = nr + a_cr_ff;
      b_in.zi    = ni + a_ci_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_done_ff  <= a_done_in;
         a_count_ff <= a_count_in;
         a_cr_ff    <= up_iter.cr;
         a_ci_ff    <= up_iter.ci;
         a_sq_ff    <= a_sq_in;
         a_xy_ff    <= a_xy_in;
      end
   end

   // only the valid bit is reset, the data follows it
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (adv) begin
         b_ff.valid <= b_in.valid;
      end
      if (adv) begin
         b_ff.done  <= b_in.done;
         b_ff.count <= b_in.count;
         b_ff.cr    <= b_in.cr;
         b_ff.ci    <= b_in.ci;
         b_ff.zr    <= b_in.zr;
         b_ff.zi    <= b_in.zi;
      end
   end

   assign dn_iter = b_ff;

`ifndef SYNTH
   // a count once fixed is never changed further down the chain
   assert property (@(posedge clock) disable iff (reset)
      adv && up_iter.valid && up_iter.done |=> a_done_ff && a_count_ff == $past(up_iter.count))
      else $error("mep_cell: settled escape count altered");

   // a fresh escape records this cell's index
   assert property (@(posedge clock) disable iff (reset)
      adv && up_iter.valid && !up_iter.done && esc |=> a_count_ff == MY_COUNT)
      else $error("mep_cell: escape count not taken from cell index");

   // a frozen cell holds its data
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(b_ff) && $stable(a_valid_ff))
      else $error("mep_cell: cell moved while frozen");
`endif

endmodule

FILE: rtl/mandelbrot_escape_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// Escape-time evaluation of one pixel per beat: coordinate mapping followed
// by a chain of iteration cells and a registered result with palette colour.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  req     | in        | req_valid/stall | req_pixel_x, req_pixel_y
//  rsp     | out       | rsp_valid/stall | rsp_escape_count, rsp_palette_index
//  csr     | in        | csr_write_enable| csr_index, csr_wdata
//
// A result passes three mapping stages, two stages per iteration cell and one
// output register. One request beat per cycle is taken while req_stall is low;
// the pipeline is set by the cell chain.
// Reset clears all valid bits and loads the view registers with their defaults.
// A stalled result freezes the whole chain and stalls the request side.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_unit import mep_pkg::*; #(
   parameter int MAX_ITER      = MAX_ITER_DEFAULT,
   parameter int FRAC_BITS     = FRAC_BITS_DEFAULT,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [8:0]        req_pixel_x,
   input  logic [7:0]        req_pixel_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [4:0]        rsp_escape_count,
   output logic [7:0]        rsp_palette_index,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   logic                     adv;
   logic signed [DATA_W-1:0] zoom_scale_ff;
   logic signed [DATA_W-1:0] offset_real_ff;
   logic signed [DATA_W-1:0] offset_imag_ff;

   mep_iter_type             chain [MAX_ITER+1];
   logic [MAX_ITER:0]        chain_valid;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [4:0]               rsp_count_ff, rsp_count_in;
   logic [7:0]               rsp_pal_ff, rsp_pal_in;

   // whole pipeline moves unless a finished beat is held at the output
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_scale_ff  <= ZOOM_SCALE_RESET;
         offset_real_ff <= OFFSET_REAL_RESET;
         offset_imag_ff <= OFFSET_IMAG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ZOOM_SCALE:  zoom_scale_ff  <= csr_wdata;
            REG_OFFSET_REAL: offset_real_ff <= csr_wdata;
            REG_OFFSET_IMAG: offset_imag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mep_map #(
      .FRAC_BITS     (FRAC_BITS),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .zoom_scale  (zoom_scale_ff),
      .offset_real (offset_real_ff),
      .offset_imag (offset_imag_ff),
      .iter_out    (chain[0])
   );

   for (genvar k = 0; k < MAX_ITER; k++) begin : g_cell
      mep_cell #(
         .FRAC_BITS (FRAC_BITS),
         .CELL_IDX  (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_iter (chain[k]),
         .dn_iter (chain[k+1])
      );
   end

   for (genvar k = 0; k <= MAX_ITER; k++) begin : g_valid
      assign chain_valid[k] = chain[k].valid;
   end

   always_comb begin
      rsp_valid_in = chain[MAX_ITER].valid;
      rsp_count_in = chain[MAX_ITER].count[4:0];
      rsp_pal_in   = palette_of(chain[MAX_ITER].count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_count_ff <= rsp_count_in;
         rsp_pal_ff   <= rsp_pal_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_escape_count  = rsp_count_ff;
   assign rsp_palette_index = rsp_pal_ff;

`ifndef SYNTH
   // nothing comes out straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("mep: result valid right after reset");

   // a held result freezes every stage of the chain
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(chain_valid))
      else $error("mep: chain moved while output held");

   // bounded points and only those get colour zero, when the count is not masked
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (MAX_ITER <= 32) |->
         ((rsp_pal_ff == 8'd0) == (rsp_count_ff == 5'd0)))
      else $error("mep: palette disagrees with escape count");

   // the escape count never reaches the iteration limit
   assert property (@(posedge clock) disable iff (reset)
      chain[MAX_ITER].valid |-> (32'(chain[MAX_ITER].count) < 32'(MAX_ITER)))
      else $error("mep: escape count out of range");
`endif

endmodule
